// ===== sv/ckl_pkg.sv =====
// Package for the counted key list table: sizes, operation and status codes, cell control.
`default_nettype none
package ckl_pkg;

  localparam int CklCapacity  = 64;
  localparam int CklKeyBits   = 16;
  localparam int CklCountBits = 16;

  localparam int ModeW   = 2;
  localparam int KeyW    = 16;
  localparam int PosW    = 6;
  localparam int StatusW = 3;
  localparam int IndexW  = 6;
  localparam int CountW  = 16;
  localparam int TotalW  = 7;

  localparam logic [ModeW-1:0] MODE_INSERT = 2'd0;
  localparam logic [ModeW-1:0] MODE_DELETE = 2'd1;

  localparam logic [StatusW-1:0] ST_NEW       = 3'd0;
  localparam logic [StatusW-1:0] ST_RAISED    = 3'd1;
  localparam logic [StatusW-1:0] ST_LOWERED   = 3'd2;
  localparam logic [StatusW-1:0] ST_REMOVED   = 3'd3;
  localparam logic [StatusW-1:0] ST_READ      = 3'd4;
  localparam logic [StatusW-1:0] ST_NOT_FOUND = 3'd5;
  localparam logic [StatusW-1:0] ST_FULL      = 3'd6;
  localparam logic [StatusW-1:0] ST_BAD_POS   = 3'd7;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic compare;  // latch this cell's pick flag
    logic by_pos;   // pick by position instead of by key
    logic insert;   // open a slot at the position and write the new key
    logic remove;   // close the slot at the removal index
    logic update;   // the picked cell loads the new count
  } ckl_ctrl_t;

endpackage
`default_nettype wire

// ===== sv/counted_key_list_table_top.sv =====
// Counted key list table: an ordered row of key/count cells with insert, delete and read.
//
// Input channel (in_valid_i / in_stall_o) carries mode, key and position; a transaction
// takes place at a clock edge with valid high and stall low. Output channel
// (out_valid_o / out_stall_i) returns exactly one result per input transaction, in order.
// Each item passes through a compare state, in which every cell compares its key (or its
// index) in parallel, and a resolve state, in which the picked cell (if any) is resolved,
// the new key or count is written, and the cells from the insert or removal point onward
// shift up or down by one cell. A new item is accepted in idle or as the last one leaves
// resolve. Its result then loads the output register. If the receiver stalls while a result waits,
// the block finishes the next item's compare and then holds it, and the input is stalled
// until the output register frees. Reset empties the table (used count zero) and clears
// both channels; cell contents are not cleared since entries beyond the used count are
// never read.
`default_nettype none
module counted_key_list_table_top #(
  parameter int CAPACITY   = ckl_pkg::CklCapacity,
  parameter int KEY_BITS   = ckl_pkg::CklKeyBits,
  parameter int COUNT_BITS = ckl_pkg::CklCountBits
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  wire  [ckl_pkg::ModeW-1:0]      mode_i,
  input  wire  [ckl_pkg::KeyW-1:0]       key_i,
  input  wire  [ckl_pkg::PosW-1:0]       position_i,
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output logic [ckl_pkg::StatusW-1:0]    status_o,
  output logic [ckl_pkg::IndexW-1:0]     found_index_o,
  output logic [ckl_pkg::KeyW-1:0]       entry_key_o,
  output logic [ckl_pkg::CountW-1:0]     entry_count_o,
  output logic [ckl_pkg::TotalW-1:0]     entry_total_o
);
  import ckl_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int UW = $clog2(CAPACITY + 1);
  localparam int CW = (UW > PosW) ? UW : PosW;

  typedef enum logic [2:0] {
    S_IDLE    = 3'b001,
    S_COMPARE = 3'b010,
    S_RESOLVE = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [ModeW-1:0]      mode_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [PosW-1:0]       pos_q;
  logic [UW-1:0]         used_q, used_d;
  logic                  out_valid_q, out_valid_d;
  logic [StatusW-1:0]    status_q, status_d;
  logic [IndexW-1:0]     index_q, index_d;
  logic [KeyW-1:0]       okey_q, okey_d;
  logic [CountW-1:0]     ocount_q, ocount_d;
  logic [TotalW-1:0]     total_q;

  logic                  in_accept;
  logic                  res_go;
  logic                  by_pos;
  ckl_ctrl_t             ctrl;
  logic                  do_insert, do_remove, do_update;
  logic [COUNT_BITS-1:0] wr_count;

  logic [KEY_BITS-1:0]   cell_key   [CAPACITY];
  logic [COUNT_BITS-1:0] cell_count [CAPACITY];
  logic [CAPACITY-1:0]   pick_vec;

  logic [KEY_BITS-1:0]   tap_key;
  logic [COUNT_BITS-1:0] tap_count;
  logic [IW-1:0]         tap_idx;
  logic                  any_pick;
  logic [CW-1:0]         pos_ext, used_ext;

  assign res_go     = (state_q == S_RESOLVE) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = !((state_q == S_IDLE) || res_go);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign by_pos     = mode_q[1];
  assign pos_ext    = CW'(pos_q);
  assign used_ext   = CW'(used_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (in_accept) state_d = S_COMPARE;
      S_COMPARE: state_d = S_RESOLVE;
      S_RESOLVE: begin
        if (res_go) state_d = in_accept ? S_COMPARE : S_IDLE;
      end
      default:   state_d = S_IDLE;
    endcase
  end

  // The keys are distinct, so at most one cell is picked and an OR tree selects it.
  always_comb begin
    tap_key   = '0;
    tap_count = '0;
    tap_idx   = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (pick_vec[i]) begin
        tap_key   = tap_key | cell_key[i];
        tap_count = tap_count | cell_count[i];
        tap_idx   = tap_idx | IW'(i);
      end
    end
  end
  assign any_pick = |pick_vec;

  always_comb begin
    status_d  = ST_BAD_POS;
    index_d   = '0;
    okey_d    = '0;
    ocount_d  = '0;
    used_d    = used_q;
    do_insert = 1'b0;
    do_remove = 1'b0;
    do_update = 1'b0;
    wr_count  = tap_count;
    if (mode_q == MODE_INSERT) begin
      if (any_pick) begin
        if (tap_count != '1) wr_count = tap_count + COUNT_BITS'(1);
        do_update = 1'b1;
        status_d  = ST_RAISED;
        index_d   = IndexW'(tap_idx);
        okey_d    = KeyW'(tap_key);
        ocount_d  = CountW'(wr_count);
      end else if (used_q == UW'(CAPACITY)) begin
        status_d = ST_FULL;
        okey_d   = KeyW'(key_q);
      end else if (pos_ext > used_ext) begin
        status_d = ST_BAD_POS;
        okey_d   = KeyW'(key_q);
      end else begin
        wr_count  = COUNT_BITS'(1);
        do_insert = 1'b1;
        used_d    = used_q + UW'(1);
        status_d  = ST_NEW;
        index_d   = pos_q;
        okey_d    = KeyW'(key_q);
        ocount_d  = CountW'(wr_count);
      end
    end else if (mode_q == MODE_DELETE) begin
      if (!any_pick) begin
        status_d = ST_NOT_FOUND;
        okey_d   = KeyW'(key_q);
      end else if (tap_count > COUNT_BITS'(1)) begin
        wr_count  = tap_count - COUNT_BITS'(1);
        do_update = 1'b1;
        status_d  = ST_LOWERED;
        index_d   = IndexW'(tap_idx);
        okey_d    = KeyW'(tap_key);
        ocount_d  = CountW'(wr_count);
      end else begin
        do_remove = 1'b1;
        used_d    = used_q - UW'(1);
        status_d  = ST_REMOVED;
        index_d   = IndexW'(tap_idx);
        okey_d    = KeyW'(tap_key);
      end
    end else begin
      if (any_pick) begin
        status_d = ST_READ;
        index_d  = pos_q;
        okey_d   = KeyW'(tap_key);
        ocount_d = CountW'(tap_count);
      end
    end
  end

  assign ctrl.compare = (state_q == S_COMPARE);
  assign ctrl.by_pos  = by_pos;
  assign ctrl.insert  = res_go && do_insert;
  assign ctrl.remove  = res_go && do_remove;
  assign ctrl.update  = res_go && do_update;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [KEY_BITS-1:0]   prev_key, next_key;
    logic [COUNT_BITS-1:0] prev_count, next_count;

    if (g == 0) begin : g_first
      assign prev_key   = '0;
      assign prev_count = '0;
    end else begin : g_prev
      assign prev_key   = cell_key[g-1];
      assign prev_count = cell_count[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign next_key   = '0;
      assign next_count = '0;
    end else begin : g_next
      assign next_key   = cell_key[g+1];
      assign next_count = cell_count[g+1];
    end

    ckl_cell #(
      .KEY_BITS   (KEY_BITS),
      .COUNT_BITS (COUNT_BITS),
      .CW         (CW),
      .IDX        (g)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .key_i        (key_q),
      .count_i      (wr_count),
      .pos_i        (pos_ext),
      .rm_idx_i     (CW'(tap_idx)),
      .used_i       (used_ext),
      .prev_key_i   (prev_key),
      .prev_count_i (prev_count),
      .next_key_i   (next_key),
      .next_count_i (next_count),
      .key_o        (cell_key[g]),
      .count_o      (cell_count[g]),
      .pick_o       (pick_vec[g])
    );
  end

  assign out_valid_d = res_go || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (res_go) used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mode_q <= mode_i;
      key_q  <= KEY_BITS'(key_i);
      pos_q  <= position_i;
    end
    if (res_go) begin
      status_q <= status_d;
      index_q  <= index_d;
      okey_q   <= okey_d;
      ocount_q <= ocount_d;
      total_q  <= TotalW'(used_d);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_index_o = index_q;
  assign entry_key_o   = okey_q;
  assign entry_count_o = ocount_q;
  assign entry_total_o = total_q;

  a_pick_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESOLVE) |-> $onehot0(pick_vec))
    else $error("more than one cell picked");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UW'(CAPACITY))
    else $error("entry total above capacity");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_go |=> out_valid_q)
    else $error("resolved item did not reach the output register");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_go && do_insert) |=> (used_q == $past(used_q) + UW'(1)))
    else $error("insert did not grow the table");

  a_remove_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_go && do_remove) |=> (used_q == $past(used_q) - UW'(1)))
    else $error("removal did not shrink the table");

endmodule
`default_nettype wire

// ===== sv/ckl_cell.sv =====
// One entry of the key list: key and count registers, compare and neighbor shift.
`default_nettype none
module ckl_cell #(
  parameter int KEY_BITS   = 16,
  parameter int COUNT_BITS = 16,
  parameter int CW         = 7,
  parameter int IDX        = 0
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  ckl_pkg::ckl_ctrl_t     ctrl_i,
  input  wire [KEY_BITS-1:0]     key_i,
  input  wire [COUNT_BITS-1:0]   count_i,
  input  wire [CW-1:0]           pos_i,
  input  wire [CW-1:0]           rm_idx_i,
  input  wire [CW-1:0]           used_i,
  input  wire [KEY_BITS-1:0]     prev_key_i,
  input  wire [COUNT_BITS-1:0]   prev_count_i,
  input  wire [KEY_BITS-1:0]     next_key_i,
  input  wire [COUNT_BITS-1:0]   next_count_i,
  output logic [KEY_BITS-1:0]    key_o,
  output logic [COUNT_BITS-1:0]  count_o,
  output logic                   pick_o
);
  import ckl_pkg::*;

  localparam logic [CW-1:0] MyIdx = CW'(IDX);

  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  pick_q, pick_d;
  logic                  occupied;

  assign occupied = MyIdx < used_i;

  always_comb begin
    pick_d = pick_q;
    if (ctrl_i.compare) begin
      if (ctrl_i.by_pos) begin
        pick_d = occupied && (MyIdx == pos_i);
      end else begin
        pick_d = occupied && (key_q == key_i);
      end
    end
  end

  always_comb begin
    key_d   = key_q;
    count_d = count_q;
    if (ctrl_i.insert) begin
      if (MyIdx > pos_i) begin
        key_d   = prev_key_i;
        count_d = prev_count_i;
      end else if (MyIdx == pos_i) begin
        key_d   = key_i;
        count_d = count_i;
      end
    end
    if (ctrl_i.remove && (MyIdx >= rm_idx_i)) begin
      key_d   = next_key_i;
      count_d = next_count_i;
    end
    if (ctrl_i.update && pick_q) begin
      count_d = count_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pick_q <= 1'b0;
    end else begin
      pick_q <= pick_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    count_q <= count_d;
  end

  assign key_o   = key_q;
  assign count_o = count_q;
  assign pick_o  = pick_q;

endmodule
`default_nettype wire
